[design/uuidp_pkg.sv]
// shared types and constants of the uuid text parser
package uuidp_pkg;

	// characters with a meaning of their own in the text
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_NUL    = 8'h00;

	// parse phases
	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_HI    = 3'd1;
	localparam logic [2:0] PH_LO    = 3'd2;
	localparam logic [2:0] PH_DASH  = 3'd3;
	localparam logic [2:0] PH_CLOSE = 3'd4;
	localparam logic [2:0] PH_END   = 3'd5;
	localparam logic [2:0] PH_DONE  = 3'd6;
	localparam logic [2:0] PH_ERR   = 3'd7;

	// number of bytes in a uuid
	localparam logic [4:0] UUID_BYTES = 5'd16;

	// classified character as it travels from front to back
	typedef struct packed {
		logic       is_hex;
		logic [3:0] nibble;
		logic       is_lbrace;
		logic       is_dash;
		logic       is_rbrace;
		logic       is_nul;
		logic       last;
	} char_class_t;

endpackage

[design/uuidp_front.sv]
// front end: classifies each incoming character
module uuidp_front
	import uuidp_pkg::*;
(
	input  logic [7:0]  ch,
	input  logic        last,
	output char_class_t cls
);

	// hex digit decode, either case
	always_comb begin
		cls           = '0;
		cls.last      = last;
		cls.is_lbrace = (ch == CH_LBRACE);
		cls.is_dash   = (ch == CH_DASH);
		cls.is_rbrace = (ch == CH_RBRACE);
		cls.is_nul    = (ch == CH_NUL);
		if (ch >= 8'h30 && ch <= 8'h39) begin
			cls.is_hex = 1'b1;
			cls.nibble = ch[3:0];
		end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
			cls.is_hex = 1'b1;
			cls.nibble = ch[3:0] + 4'd9;
		end
	end

endmodule

[design/uuidp_queue.sv]
// two-entry queue between the front and back ends
module uuidp_queue
	import uuidp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_valid,
	input  char_class_t wr_data,
	output logic        full,
	output logic        rd_valid,
	output char_class_t rd_data,
	input  logic        rd_pop
);

	char_class_t mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic        pop;

	assign full     = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && !full;
	assign pop      = rd_pop && rd_valid;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[design/uuidp_back.sv]
// back end: parse state machine and result register
module uuidp_back
	import uuidp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  char_class_t q_data,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] uuid_high,
	output logic [63:0] uuid_low,
	output logic        status
);

	logic [2:0]  phase_q;
	logic [4:0]  byte_count_q;
	logic        brace_open_q;
	logic [3:0]  high_nibble_q;
	logic [63:0] word_hi_q;
	logic [63:0] word_lo_q;
	logic        out_valid_q;
	logic [63:0] uuid_high_q;
	logic [63:0] uuid_low_q;
	logic        status_q;

	logic [2:0]  phase_n;
	logic [4:0]  byte_count_n;
	logic        brace_open_n;
	logic [3:0]  high_nibble_n;
	logic [63:0] word_hi_n;
	logic [63:0] word_lo_n;
	logic        text_ok;

	assign q_pop     = q_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign uuid_high = uuid_high_q;
	assign uuid_low  = uuid_low_q;
	assign status    = status_q;

	// next parse state for the beat at the queue head
	always_comb begin
		phase_n       = phase_q;
		byte_count_n  = byte_count_q;
		brace_open_n  = brace_open_q;
		high_nibble_n = high_nibble_q;
		word_hi_n     = word_hi_q;
		word_lo_n     = word_lo_q;
		unique case (phase_q) inside
			PH_START, PH_HI, PH_DASH: begin
				if (phase_q == PH_START && q_data.is_lbrace) begin
					brace_open_n = 1'b1;
					phase_n      = PH_HI;
				end else if (phase_q == PH_DASH && q_data.is_dash) begin
					phase_n = PH_HI;
				end else if (q_data.is_hex) begin
					high_nibble_n = q_data.nibble;
					phase_n       = PH_LO;
				end else begin
					phase_n = PH_ERR;
				end
			end
			PH_LO: begin
				if (q_data.is_hex) begin
					if (!byte_count_q[3]) begin
						word_hi_n = {word_hi_q[55:0], high_nibble_q, q_data.nibble};
					end else begin
						word_lo_n = {word_lo_q[55:0], high_nibble_q, q_data.nibble};
					end
					byte_count_n = byte_count_q + 5'd1;
					if (byte_count_n >= UUID_BYTES) begin
						phase_n = brace_open_q ? PH_CLOSE : PH_END;
					end else if (!byte_count_n[0]) begin
						phase_n = PH_DASH;
					end else begin
						phase_n = PH_HI;
					end
				end else begin
					phase_n = PH_ERR;
				end
			end
			PH_CLOSE: phase_n = q_data.is_rbrace ? PH_END : PH_ERR;
			PH_END:   phase_n = q_data.is_nul ? PH_DONE : PH_ERR;
			default:  phase_n = phase_q;
		endcase
	end

	assign text_ok = (phase_n == PH_END) || (phase_n == PH_DONE);

	// parse state, back to start after the closing beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_START;
			byte_count_q  <= 5'd0;
			brace_open_q  <= 1'b0;
			high_nibble_q <= 4'd0;
		end else if (q_pop) begin
			if (q_data.last) begin
				phase_q       <= PH_START;
				byte_count_q  <= 5'd0;
				brace_open_q  <= 1'b0;
				high_nibble_q <= 4'd0;
			end else begin
				phase_q       <= phase_n;
				byte_count_q  <= byte_count_n;
				brace_open_q  <= brace_open_n;
				high_nibble_q <= high_nibble_n;
			end
		end
	end

	// assembled uuid words
	always_ff @(posedge clk) begin
		if (q_pop) begin
			word_hi_q <= word_hi_n;
			word_lo_q <= word_lo_n;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop && q_data.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, zero on a syntax error
	always_ff @(posedge clk) begin
		if (q_pop && q_data.last) begin
			uuid_high_q <= text_ok ? word_hi_n : 64'd0;
			uuid_low_q  <= text_ok ? word_lo_n : 64'd0;
			status_q    <= !text_ok;
		end
	end

endmodule

[design/uuid_text_parser_unit.sv]
// Streaming UUID text parser, top level. One character beat is taken per clock;
// the character is classified on entry, held in a two-entry queue, and run
// through the parse state machine, whose result register is filled by the beat
// marked last. The last beat of a text passes through the queue entry and then
// the result register before its result is shown; a new text may begin on the
// very next beat. Sustained rate is one character per cycle, set by the state
// update at the queue head; the input stalls only while the queue is full behind
// a stalled result.
module uuid_text_parser_unit
	import uuidp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  ch,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] uuid_high,
	output logic [63:0] uuid_low,
	output logic        status
);

	char_class_t cls;
	char_class_t head;
	logic        q_full;
	logic        q_valid;
	logic        q_pop;

	assign in_stall = q_full;

	// character classification
	uuidp_front u_front (
		.ch   (ch),
		.last (last),
		.cls  (cls)
	);

	// decoupling queue
	uuidp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (in_valid),
		.wr_data  (cls),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_data  (head),
		.rd_pop   (q_pop)
	);

	// parse and result
	uuidp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.uuid_high (uuid_high),
		.uuid_low  (uuid_low),
		.status    (status)
	);

endmodule
